// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RHF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define RHF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rhf_pkg.sv -----
// ---------------------------------------------------------------------------
// rhf_pkg
// Types and fixed constants of the remap hole filling unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rhf_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 12;
   localparam int HOLE_BITS      = 24;
   localparam int CNT_BITS       = 4;
   localparam int NBR_COUNT      = 8;
   localparam int WIN_CELLS      = 9;
   localparam int CENTRE_CELL    = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic [CSR_DATA_BITS-1:0] FRAME_WIDTH_RESET  = CSR_DATA_BITS'(1032);
   localparam logic [CSR_DATA_BITS-1:0] FRAME_HEIGHT_RESET = CSR_DATA_BITS'(778);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SUM,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic shift_en;
   } lb_ctrl_type;

   typedef struct packed {
      logic                 sum_en;
      logic                 mul_en;
      logic [NBR_COUNT-1:0] in_frame;
   } lane_ctrl_type;

   // Window cell of neighbour j, skipping the centre.
   function automatic int nbr_cell(input int j);
      return (j < CENTRE_CELL) ? j : j + 1;
   endfunction

endpackage

`default_nettype wire

// ----- sv/rhf_line_buffer.sv -----
// ---------------------------------------------------------------------------
// rhf_line_buffer
// Two row memories and the 3x3 window of x and y entries.
// ---------------------------------------------------------------------------
`default_nettype none

module rhf_line_buffer #(
   parameter int MAX_WIDTH  = 2048,
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  rhf_pkg::lb_ctrl_type         ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   output logic signed [COORD_BITS-1:0] win_x [0:rhf_pkg::WIN_CELLS-1],
   output logic signed [COORD_BITS-1:0] win_y [0:rhf_pkg::WIN_CELLS-1]
);
   import rhf_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WORD_BITS = 2 * COORD_BITS;

   logic [WORD_BITS-1:0] upper_row_store  [0:MAX_WIDTH-1];
   logic [WORD_BITS-1:0] middle_row_store [0:MAX_WIDTH-1];

   logic [WORD_BITS-1:0]         upper_rd_ff;
   logic [WORD_BITS-1:0]         middle_rd_ff;
   logic [COL_BITS-1:0]          addr_ff;
   logic signed [COORD_BITS-1:0] win_x_ff [0:WIN_CELLS-1];
   logic signed [COORD_BITS-1:0] win_y_ff [0:WIN_CELLS-1];

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         upper_rd_ff <= upper_row_store[addr];
         addr_ff     <= addr;
      end
      if (ctrl.shift_en) begin
         upper_row_store[addr_ff] <= middle_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         middle_rd_ff <= middle_row_store[addr];
      end
      if (ctrl.shift_en) begin
         middle_row_store[addr_ff] <= {in_x, in_y};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_x_ff[3*r]     <= win_x_ff[3*r + 1];
            win_x_ff[3*r + 1] <= win_x_ff[3*r + 2];
            win_y_ff[3*r]     <= win_y_ff[3*r + 1];
            win_y_ff[3*r + 1] <= win_y_ff[3*r + 2];
         end
         win_x_ff[2] <= upper_rd_ff[WORD_BITS-1:COORD_BITS];
         win_y_ff[2] <= upper_rd_ff[COORD_BITS-1:0];
         win_x_ff[5] <= middle_rd_ff[WORD_BITS-1:COORD_BITS];
         win_y_ff[5] <= middle_rd_ff[COORD_BITS-1:0];
         win_x_ff[8] <= in_x;
         win_y_ff[8] <= in_y;
      end
   end

   assign win_x = win_x_ff;
   assign win_y = win_y_ff;

endmodule

`default_nettype wire

// ----- sv/rhf_fill_lane.sv -----
// ---------------------------------------------------------------------------
// rhf_fill_lane
// Neighbour sum, count and reciprocal division for one coordinate.
// ---------------------------------------------------------------------------
`default_nettype none

module rhf_fill_lane #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  rhf_pkg::lane_ctrl_type       ctrl,
   input  logic signed [COORD_BITS-1:0] window [0:rhf_pkg::WIN_CELLS-1],
   output logic signed [COORD_BITS-1:0] filled,
   output logic                         unfilled
);
   import rhf_pkg::*;

   localparam int SUM_BITS   = COORD_BITS + 2;
   localparam int SHIFT      = SUM_BITS + 3;
   localparam int RECIP_BITS = SHIFT + 1;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;

   localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(2**SHIFT);
   localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'((2**SHIFT + 1) / 2);
   localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'((2**SHIFT + 2) / 3);
   localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'((2**SHIFT + 3) / 4);
   localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'((2**SHIFT + 4) / 5);
   localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'((2**SHIFT + 5) / 6);
   localparam logic [RECIP_BITS-1:0] RECIP_7 = RECIP_BITS'((2**SHIFT + 6) / 7);
   localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'((2**SHIFT + 7) / 8);

   logic [SUM_BITS-1:0]          sum_in;
   logic [CNT_BITS-1:0]          cnt_in;
   logic [SUM_BITS-1:0]          sum_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic signed [COORD_BITS-1:0] centre_ff;
   logic [RECIP_BITS-1:0]        recip;
   logic [PROD_BITS-1:0]         prod_ff;

   always_comb begin
      sum_in = '0;
      cnt_in = '0;
      for (int j = 0; j < NBR_COUNT; j++) begin
         if (ctrl.in_frame[j] && !window[nbr_cell(j)][COORD_BITS-1]) begin
            sum_in = sum_in + SUM_BITS'(window[nbr_cell(j)][COORD_BITS-2:0]);
            cnt_in = cnt_in + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
         centre_ff <= window[CENTRE_CELL];
      end
   end

   always_comb begin
      unique case (cnt_ff)
         CNT_BITS'(2): recip = RECIP_2;
         CNT_BITS'(3): recip = RECIP_3;
         CNT_BITS'(4): recip = RECIP_4;
         CNT_BITS'(5): recip = RECIP_5;
         CNT_BITS'(6): recip = RECIP_6;
         CNT_BITS'(7): recip = RECIP_7;
         CNT_BITS'(8): recip = RECIP_8;
         default:      recip = RECIP_1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= PROD_BITS'(sum_ff) * PROD_BITS'(recip);
      end
   end

   always_comb begin
      unfilled = centre_ff[COORD_BITS-1] && (cnt_ff == '0);
      if (!centre_ff[COORD_BITS-1] || (cnt_ff == '0)) begin
         filled = centre_ff;
      end else begin
         filled = signed'(prod_ff[SHIFT +: COORD_BITS]);
      end
   end

endmodule

`default_nettype wire

// ----- sv/remap_hole_fill_3x3_unit.sv -----
// Remap hole filler, 3x3 neighbourhood. One input transfer carries an x and
// a y remap entry in raster order, or a drain; a result for a pixel appears
// once the pixel one row plus one column later has been taken, and after the
// whole frame each further transfer flushes one result. An item that moves
// the window but yields no result occupies the unit for the registered read
// of the two row memories and then the write-back and window shift; an item
// that yields a result occupies the unit through shift, neighbour sum,
// reciprocal multiply and the load of the result into the output register,
// which waits only while the previous result has not been taken. A drain
// before the frame is complete yields nothing. The row memories hold one
// row each of MAX_WIDTH entries and need no clearing after reset; a write
// of either frame register restarts the frame.
// ---------------------------------------------------------------------------
// remap_hole_fill_3x3_unit
// Top level: frame counters, sequencer, output register and hole count.
// ---------------------------------------------------------------------------
`default_nettype none

module remap_hole_fill_3x3_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_BITS-1:0]         req_x_entry,
   input  logic signed [COORD_BITS-1:0]         req_y_entry,
   input  logic                                 req_drain,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [COORD_BITS-1:0]         rsp_x_filled,
   output logic signed [COORD_BITS-1:0]         rsp_y_filled,
   output logic                                 rsp_x_unfilled,
   output logic                                 rsp_y_unfilled,
   output logic                                 rsp_last_pixel,
   output logic [rhf_pkg::HOLE_BITS-1:0]        rsp_unfilled_total,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rhf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rhf_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import rhf_pkg::*;

   localparam int DIM_W_BITS = $clog2(MAX_WIDTH + 1);
   localparam int DIM_H_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = DIM_H_BITS;

   state_type                    state_ff, state_in;
   logic [CSR_DATA_BITS-1:0]     frame_width_ff, frame_height_ff;
   logic [COL_BITS-1:0]          in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]          in_row_ff, in_row_in;
   logic [COL_BITS-1:0]          out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]          out_row_ff, out_row_in;
   logic [HOLE_BITS-1:0]         hole_count_ff, hole_count_in;
   logic                         emit_ff;
   logic signed [COORD_BITS-1:0] item_x_ff, item_y_ff;
   logic                         rsp_valid_ff;

   logic [31:0]                  fw_ext, fh_ext;
   logic [DIM_W_BITS-1:0]        w_dim;
   logic [DIM_H_BITS-1:0]        h_dim;
   logic                         req_xfer, csr_xfer, csr_restart;
   logic                         frame_done, past_first_row;
   logic                         do_shift, do_emit;
   logic                         in_col_wrap, out_col_wrap, out_row_last, out_last;
   logic                         out_load;
   logic [HOLE_BITS:0]           hole_sum;
   logic [HOLE_BITS-1:0]         hole_next;

   lb_ctrl_type                  lb_ctrl;
   lane_ctrl_type                lane_ctrl;
   logic                         top_ok, bot_ok, left_ok, right_ok;
   logic signed [COORD_BITS-1:0] win_x [0:WIN_CELLS-1];
   logic signed [COORD_BITS-1:0] win_y [0:WIN_CELLS-1];
   logic signed [COORD_BITS-1:0] x_fill, y_fill;
   logic                         x_unf, y_unf;

   // Frame dimensions clamped to the supported range.
   always_comb begin
      fw_ext = 32'(frame_width_ff);
      fh_ext = 32'(frame_height_ff);
      if (fw_ext < 32'd3) begin
         w_dim = DIM_W_BITS'(3);
      end else if (fw_ext > 32'(MAX_WIDTH)) begin
         w_dim = DIM_W_BITS'(MAX_WIDTH);
      end else begin
         w_dim = DIM_W_BITS'(fw_ext);
      end
      if (fh_ext < 32'd3) begin
         h_dim = DIM_H_BITS'(3);
      end else if (fh_ext > 32'(MAX_HEIGHT)) begin
         h_dim = DIM_H_BITS'(MAX_HEIGHT);
      end else begin
         h_dim = DIM_H_BITS'(fh_ext);
      end
   end

   assign csr_ready   = 1'b1;
   assign csr_xfer    = csr_valid && csr_ready;
   assign csr_restart = csr_xfer &&
                        ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign frame_done     = (in_row_ff == h_dim);
   assign past_first_row = (in_row_ff >= ROW_BITS'(2)) ||
                           ((in_row_ff == ROW_BITS'(1)) && (in_col_ff != '0));
   assign do_shift = req_xfer && (!req_drain || frame_done);
   assign do_emit  = frame_done || (!req_drain && past_first_row);

   assign in_col_wrap  = ((DIM_W_BITS'(in_col_ff) + DIM_W_BITS'(1)) == w_dim);
   assign out_col_wrap = ((DIM_W_BITS'(out_col_ff) + DIM_W_BITS'(1)) == w_dim);
   assign out_row_last = ((out_row_ff + ROW_BITS'(1)) == h_dim);
   assign out_last     = out_col_wrap && out_row_last;

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      hole_sum = {1'b0, hole_count_ff} + (HOLE_BITS + 1)'(x_unf) + (HOLE_BITS + 1)'(y_unf);
      if (hole_sum[HOLE_BITS]) begin
         hole_next = '1;
      end else begin
         hole_next = hole_sum[HOLE_BITS-1:0];
      end
   end

   always_comb begin
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      hole_count_in = hole_count_ff;
      priority if (csr_restart) begin
         in_col_in     = '0;
         in_row_in     = '0;
         out_col_in    = '0;
         out_row_in    = '0;
         hole_count_in = '0;
      end else if (do_shift) begin
         if (in_col_wrap) begin
            in_col_in = '0;
            if (!frame_done) begin
               in_row_in = in_row_ff + ROW_BITS'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
      end else if (out_load) begin
         if (out_last) begin
            in_col_in     = '0;
            in_row_in     = '0;
            out_col_in    = '0;
            out_row_in    = '0;
            hole_count_in = '0;
         end else begin
            hole_count_in = hole_next;
            if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_BITS'(1);
            end else begin
               out_col_in = out_col_ff + COL_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_shift) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            state_in = emit_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      top_ok   = (out_row_ff != '0);
      bot_ok   = !out_row_last;
      left_ok  = (out_col_ff != '0);
      right_ok = !out_col_wrap;

      lb_ctrl.rd_en    = do_shift;
      lb_ctrl.shift_en = (state_ff == ST_SHIFT);

      lane_ctrl.sum_en   = (state_ff == ST_SUM);
      lane_ctrl.mul_en   = (state_ff == ST_MUL);
      lane_ctrl.in_frame = {bot_ok && right_ok, bot_ok, bot_ok && left_ok,
                            right_ok, left_ok,
                            top_ok && right_ok, top_ok, top_ok && left_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         hole_count_ff   <= '0;
         emit_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         hole_count_ff <= hole_count_in;
         if (csr_xfer && (csr_index == CSR_FRAME_WIDTH)) begin
            frame_width_ff <= csr_data;
         end
         if (csr_xfer && (csr_index == CSR_FRAME_HEIGHT)) begin
            frame_height_ff <= csr_data;
         end
         if (req_xfer) begin
            emit_ff <= do_emit;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_x_ff <= req_x_entry;
         item_y_ff <= req_y_entry;
      end
      if (out_load) begin
         rsp_x_filled       <= x_fill;
         rsp_y_filled       <= y_fill;
         rsp_x_unfilled     <= x_unf;
         rsp_y_unfilled     <= y_unf;
         rsp_last_pixel     <= out_last;
         rsp_unfilled_total <= hole_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   rhf_line_buffer #(
      .MAX_WIDTH  (MAX_WIDTH),
      .COORD_BITS (COORD_BITS)
   ) u_line_buffer (
      .clock (clock),
      .ctrl  (lb_ctrl),
      .addr  (in_col_ff),
      .in_x  (item_x_ff),
      .in_y  (item_y_ff),
      .win_x (win_x),
      .win_y (win_y)
   );

   rhf_fill_lane #(
      .COORD_BITS (COORD_BITS)
   ) u_lane_x (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .window   (win_x),
      .filled   (x_fill),
      .unfilled (x_unf)
   );

   rhf_fill_lane #(
      .COORD_BITS (COORD_BITS)
   ) u_lane_y (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .window   (win_y),
      .filled   (y_fill),
      .unfilled (y_unf)
   );

endmodule

`default_nettype wire

// ----- sv/rhf_checker.sv -----
// ---------------------------------------------------------------------------
// rhf_checker
// Port-level checks on the result channel of the hole filling unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rhf_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_BITS-1:0]  rsp_x_filled,
   input logic signed [COORD_BITS-1:0]  rsp_y_filled,
   input logic                          rsp_x_unfilled,
   input logic                          rsp_y_unfilled,
   input logic [rhf_pkg::HOLE_BITS-1:0] rsp_unfilled_total
);

   logic stalled;
   logic x_negative;
   logic y_negative;

   assign stalled    = rsp_valid && !rsp_ready;
   assign x_negative = rsp_x_filled[COORD_BITS-1];
   assign y_negative = rsp_y_filled[COORD_BITS-1];

   // A stalled result keeps its valid and its running total.
   `RHF_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid, "rsp_valid dropped")
   `RHF_ASSERT_NEXT(a_total_hold, clock, reset, stalled, $stable(rsp_unfilled_total), "total moved")

   // An entry is negative on output exactly when it is an unfilled hole.
   `RHF_ASSERT_IMPL(a_x_flag, clock, reset, rsp_valid, x_negative == rsp_x_unfilled, "x flag wrong")
   `RHF_ASSERT_IMPL(a_y_flag, clock, reset, rsp_valid, y_negative == rsp_y_unfilled, "y flag wrong")

   // Nothing is offered in the cycle after reset.
   `RHF_ASSERT_IMPL(a_reset_quiet, clock, 1'b0, $past(reset) && !reset, !rsp_valid, "early result")

endmodule

bind remap_hole_fill_3x3_unit rhf_checker #(
   .COORD_BITS (COORD_BITS)
) u_rhf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_x_filled       (rsp_x_filled),
   .rsp_y_filled       (rsp_y_filled),
   .rsp_x_unfilled     (rsp_x_unfilled),
   .rsp_y_unfilled     (rsp_y_unfilled),
   .rsp_unfilled_total (rsp_unfilled_total)
);

`default_nettype wire
